// ===== rtl/smn_pkg.sv =====
// Shared constants and controller/datapath interface types for the softmax block.
package smn_pkg;

    localparam int MAX_LEN_DEF  = 64;
    localparam int LOGIT_W      = 16;
    localparam int E_W          = 16;
    localparam int SUM_W        = 22;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;
    localparam int QBITS        = 55;
    localparam int TAYLOR_TERMS = 26;
    localparam int EXP_CUTOFF   = 2839;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take the request element
        logic idx_clr;
        logic idx_inc;
        logic x_start;  // start exponential of the element at idx
        logic x_store;  // store e and accumulate the sum
        logic d_start;  // start normalizing divide
        logic emit;     // register a result
        logic finish;   // end of vector clear
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exp_rdy;
        logic x_done;
        logic d_done;
        logic last_idx;
    } t_dp_sts;

endpackage

// ===== rtl/smn_exp.sv =====
// Iterative exponential unit: round(32768*exp(-k/256)) through a Q55 Taylor series and products.
module smn_exp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smn_pkg::LOGIT_W-1:0] i_k,
    output logic                      o_ready,
    output logic                      o_done,
    output logic [smn_pkg::E_W-1:0]   o_e
);

    localparam int QW = smn_pkg::QBITS + 1;
    localparam logic [2:0] X_IDLE = 3'd0;
    localparam logic [2:0] X_TMUL = 3'd1;
    localparam logic [2:0] X_TDIV = 3'd2;
    localparam logic [2:0] X_TACC = 3'd3;
    localparam logic [2:0] X_TSUB = 3'd4;
    localparam logic [2:0] X_MUL  = 3'd5;
    localparam logic [2:0] X_RND  = 3'd6;
    localparam logic [QW-1:0] QONE = QW'(1) << smn_pkg::QBITS;
    localparam logic [4:0] LAST_N  = 5'(smn_pkg::TAYLOR_TERMS);

    logic [2:0]    r_st;
    logic          r_init;
    logic [QW-1:0] r_e1, r_term, r_neg, r_num, r_v;
    logic [QW:0]   r_pos;
    logic [4:0]    r_rem, r_n;
    logic [2:0]    r_dcnt;
    logic [8:0]    r_r;
    logic [3:0]    r_q;
    logic [1:0]    r_mstep;
    logic [63:0]   r_mid;
    logic [15:0]   r_e;
    logic          r_done;

    logic [64:0]   tprod;
    logic [QW-1:0] n_num;
    logic [4:0]    n_rem;
    logic [31:0]   ma, mb;
    logic [63:0]   mprod;
    logic [QW:0]   rnd;

    // Term product for the series
    assign tprod = 65'(r_term) * 65'(r_r);

    // Eight quotient bits per cycle of the term divide by n
    always_comb begin
        logic [5:0] rem6;
        n_num = r_num;
        n_rem = r_rem;
        for (int j = 0; j < 8; j++) begin
            rem6  = {n_rem, n_num[QW-1]};
            n_num = {n_num[QW-2:0], 1'b0};
            if (rem6 >= {1'b0, r_n}) begin
                n_rem    = 5'(rem6 - {1'b0, r_n});
                n_num[0] = 1'b1;
            end else begin
                n_rem = rem6[4:0];
            end
        end
    end

    // One 32x32 partial product per step of the Q55 product
    assign ma    = r_mstep[1] ? 32'(r_v[QW-1:32]) : r_v[31:0];
    assign mb    = r_mstep[0] ? 32'(r_e1[QW-1:32]) : r_e1[31:0];
    assign mprod = 64'(ma) * 64'(mb);
    assign rnd   = (QW+1)'(r_v) + ((QW+1)'(1) << 39);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // compute exp(-1) once after reset
            r_st   <= X_TMUL;
            r_init <= 1'b1;
            r_term <= QONE;
            r_pos  <= (QW+1)'(QONE);
            r_neg  <= '0;
            r_n    <= 5'd1;
            r_r    <= 9'd256;
            r_q    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                X_IDLE: begin
                    if (i_start) begin
                        if (i_k > 16'(smn_pkg::EXP_CUTOFF)) begin
                            r_e    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_r    <= {1'b0, i_k[7:0]};
                            r_q    <= i_k[11:8];
                            r_term <= QONE;
                            r_pos  <= (QW+1)'(QONE);
                            r_neg  <= '0;
                            r_n    <= 5'd1;
                            r_st   <= X_TMUL;
                        end
                    end
                end
                X_TMUL: begin
                    r_num  <= tprod[63:8];
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    r_st   <= X_TDIV;
                end
                X_TDIV: begin
                    r_num  <= n_num;
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'd6) begin
                        r_st <= X_TACC;
                    end
                end
                X_TACC: begin
                    r_term <= r_num;
                    if (r_n[0]) begin
                        r_neg <= r_neg + r_num;
                    end else begin
                        r_pos <= r_pos + (QW+1)'(r_num);
                    end
                    if (r_n == LAST_N) begin
                        r_st <= X_TSUB;
                    end else begin
                        r_n  <= r_n + 5'd1;
                        r_st <= X_TMUL;
                    end
                end
                X_TSUB: begin
                    r_mstep <= '0;
                    if (r_init) begin
                        r_e1   <= QW'(r_pos - (QW+1)'(r_neg));
                        r_init <= 1'b0;
                        r_st   <= X_IDLE;
                    end else begin
                        r_v  <= QW'(r_pos - (QW+1)'(r_neg));
                        r_st <= (r_q == 4'd0) ? X_RND : X_MUL;
                    end
                end
                X_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    case (r_mstep)
                        2'd0:    r_mid <= 64'(mprod[63:32]);
                        2'd3: begin
                            r_v <= QW'((mprod << 9) + (r_mid >> 23));
                            r_q <= r_q - 4'd1;
                            if (r_q == 4'd1) begin
                                r_st <= X_RND;
                            end
                        end
                        default: r_mid <= r_mid + mprod;
                    endcase
                end
                X_RND: begin
                    r_e    <= rnd[55:40];
                    r_done <= 1'b1;
                    r_st   <= X_IDLE;
                end
                default: r_st <= X_IDLE;
            endcase
        end
    end

    assign o_ready = (r_st == X_IDLE);
    assign o_done  = r_done;
    assign o_e     = r_e;

endmodule

// ===== rtl/smn_div.sv =====
// Serial restoring divider for the normalizing step, one quotient bit per cycle.
module smn_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [22:0] i_den,
    output logic        o_done,
    output logic [15:0] o_q
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_qn;
    logic [22:0] r_rem, r_den;
    logic [23:0] rem2;

    assign rem2 = {r_rem, r_qn[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_qn   <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= 23'(rem2 - {1'b0, r_den});
                    r_qn  <= {r_qn[30:0], 1'b1};
                end else begin
                    r_rem <= rem2[22:0];
                    r_qn  <= {r_qn[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_qn[15:0];

endmodule

// ===== rtl/smn_dp.sv =====
// Datapath: element and exponent stores, running max, sum, index and result registers.
module smn_dp #(
    parameter int MAX_LEN = smn_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smn_pkg::t_dp_cmd            i_cmd,
    output smn_pkg::t_dp_sts            o_sts,
    input  logic signed [smn_pkg::LOGIT_W-1:0] i_logit,
    output logic                        o_strobe,
    output logic [smn_pkg::E_W-1:0]     o_probability,
    output logic [smn_pkg::POS_W-1:0]   o_position,
    output logic                        o_final_res,
    output logic                        o_truncated
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = smn_pkg::CNT_W;

    logic signed [smn_pkg::LOGIT_W-1:0] mem_x [MAX_LEN];
    logic [smn_pkg::E_W-1:0]            mem_e [MAX_LEN];

    logic signed [smn_pkg::LOGIT_W-1:0] r_xrd, r_max;
    logic [smn_pkg::E_W-1:0]            r_erd;
    logic [CW-1:0]                      r_count, r_idx;
    logic [smn_pkg::SUM_W-1:0]          r_sum;
    logic                               r_ovf, r_strobe;
    logic [smn_pkg::E_W-1:0]            r_prob;
    logic [smn_pkg::POS_W-1:0]          r_pos;
    logic                               r_fin, r_trunc;

    logic [16:0] diff;
    logic        x_rdy, x_done, d_done;
    logic [15:0] x_e, d_q;
    logic        room;

    assign room = (r_count < CW'(MAX_LEN));
    assign diff = {r_max[15], r_max} - {r_xrd[15], r_xrd};

    // Stores, written and read once a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            mem_x[r_count[AW-1:0]] <= i_logit;
        end
        if (i_cmd.x_store) begin
            mem_e[r_idx[AW-1:0]] <= x_e;
        end
        r_xrd <= mem_x[r_idx[AW-1:0]];
        r_erd <= mem_e[r_idx[AW-1:0]];
    end

    // Running max, count, sum, overflow, index and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.load) begin
                if (room) begin
                    if (r_count == '0 || i_logit > r_max) begin
                        r_max <= i_logit;
                    end
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.x_store) begin
                r_sum <= r_sum + smn_pkg::SUM_W'(x_e);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_sum   <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_prob  <= d_q;
            r_pos   <= r_idx[smn_pkg::POS_W-1:0];
            r_fin   <= o_sts.last_idx;
            r_trunc <= r_ovf;
        end
    end

    smn_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.x_start),
        .i_k     (diff[15:0]),
        .o_ready (x_rdy),
        .o_done  (x_done),
        .o_e     (x_e)
    );

    smn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.d_start),
        .i_num   ({r_erd, 16'h0000} + 32'(r_sum)),
        .i_den   ({r_sum, 1'b0}),
        .o_done  (d_done),
        .o_q     (d_q)
    );

    assign o_sts.exp_rdy  = x_rdy;
    assign o_sts.x_done   = x_done;
    assign o_sts.d_done   = d_done;
    assign o_sts.last_idx = (r_idx == r_count - CW'(1));

    assign o_strobe      = r_strobe;
    assign o_probability = r_prob;
    assign o_position    = r_pos;
    assign o_final_res   = r_fin;
    assign o_truncated   = r_trunc;

endmodule

// ===== rtl/smn_ctrl.sv =====
// Controller: accepts elements, then sequences the exponent pass and the divide pass.
module smn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last,
    output logic             busy,
    output smn_pkg::t_dp_cmd o_cmd,
    input  smn_pkg::t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_XRD  = 3'd1;
    localparam logic [2:0] S_XGO  = 3'd2;
    localparam logic [2:0] S_XWT  = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DGO  = 3'd5;
    localparam logic [2:0] S_DWT  = 3'd6;

    logic [2:0] r_st, n_st;
    logic       accept;

    assign busy   = (r_st != S_IDLE) || !i_sts.exp_rdy;
    assign accept = start && !busy;

    // Next state and commands
    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept && i_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_st          = S_XRD;
                end
            end
            S_XRD: n_st = S_XGO;
            S_XGO: begin
                o_cmd.x_start = 1'b1;
                n_st          = S_XWT;
            end
            S_XWT: begin
                if (i_sts.x_done) begin
                    o_cmd.x_store = 1'b1;
                    if (i_sts.last_idx) begin
                        o_cmd.idx_clr = 1'b1;
                        n_st          = S_DRD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_st          = S_XRD;
                    end
                end
            end
            S_DRD: n_st = S_DGO;
            S_DGO: begin
                o_cmd.d_start = 1'b1;
                n_st          = S_DWT;
            end
            S_DWT: begin
                if (i_sts.d_done) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_idx) begin
                        o_cmd.finish = 1'b1;
                        n_st         = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_st          = S_DRD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// ===== rtl/softmax_normalize.sv =====
// Each element request is taken when start is high and busy is low; a non-last request
// leaves busy low. On the last request busy rises for an exponent pass over every stored
// element (26 series terms in the shared exponential unit, then q products with exp(-1),
// q = whole units of max-x; past the cutoff the result is zero), then a divide pass
// through the serial divider; one result strobes per divide. Results cannot be stalled.
// Synchronous active-low reset clears all control; busy then stays high until exp(-1) is ready.
module softmax_normalize #(
    parameter int MAX_LEN = smn_pkg::MAX_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [smn_pkg::LOGIT_W-1:0] i_logit,
    input  logic                               i_last,
    output logic                               o_strobe,
    output logic [smn_pkg::E_W-1:0]            o_probability,
    output logic [smn_pkg::POS_W-1:0]          o_position,
    output logic                               o_final_res,
    output logic                               o_truncated
);

    smn_pkg::t_dp_cmd cmd;
    smn_pkg::t_dp_sts sts;

    smn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    smn_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_logit       (i_logit),
        .o_strobe      (o_strobe),
        .o_probability (o_probability),
        .o_position    (o_position),
        .o_final_res   (o_final_res),
        .o_truncated   (o_truncated)
    );

endmodule
